### hdl/tcq_pkg.sv
package tcq_pkg;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_BOTH      = 3'd1,
        EV_BOTH_LONG = 3'd2,
        EV_LONG_REL  = 3'd3,
        EV_NEXT      = 3'd4,
        EV_PREV      = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        REG_DEBOUNCE   = 2'd0,
        REG_LONG_PRESS = 2'd1,
        REG_IDLE_LIMIT = 2'd2
    } cfg_reg_t;

    localparam int DEBOUNCE_W   = 16;
    localparam int LONG_PRESS_W = 20;
    localparam int IDLE_LIMIT_W = 32;
    localparam int STAMP_IN_W   = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;

endpackage

### hdl/two_button_chord_qualifier.sv
// Qualifies two active-low buttons, next and prev, from timestamped poll
// requests, and gives one result per request: a chord press, a long chord
// press, a release after a long press, or a debounced single press, along
// with the idle time since the last activity and an idle flag. A request with
// func set restarts the inactivity timer instead of sampling the buttons.
// Each request is registered on entry, evaluated combinationally against
// the button state, and the result is registered on the output, so one
// request is taken every clock cycle while the output is not stalled. The
// input register keeps taking requests while a result waits at the output,
// and the input stalls only when both registers are full. Timestamps are
// TIME_BITS wide and their differences wrap; an unused config index is
// ignored. The user must write the configuration registers through cfg_we,
// cfg_index and cfg_data only while no request is in flight (not enforced).
module two_button_chord_qualifier
    import tcq_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,

    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,

    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic                    next_level,
    input  logic                    prev_level,
    input  logic [STAMP_IN_W-1:0]   now_ms,

    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [2:0]              event_res,
    output logic [31:0]             idle_ms,
    output logic                    idle
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    logic [DEBOUNCE_W-1:0]   debounce_reg;
    logic [LONG_PRESS_W-1:0] long_press_reg;
    logic [IDLE_LIMIT_W-1:0] idle_limit_reg;

    logic                  s1_valid_reg;
    logic                  s1_func_reg;
    logic                  s1_next_reg;
    logic                  s1_prev_reg;
    logic [STAMP_IN_W-1:0] s1_now_reg;

    logic                 next_held_reg, next_held_next;
    logic                 prev_held_reg, prev_held_next;
    logic                 chord_held_reg, chord_held_next;
    logic                 long_rep_reg, long_rep_next;
    logic [TIME_BITS-1:0] next_stamp_reg, next_stamp_next;
    logic [TIME_BITS-1:0] prev_stamp_reg, prev_stamp_next;
    logic [TIME_BITS-1:0] chord_stamp_reg, chord_stamp_next;
    logic [TIME_BITS-1:0] act_stamp_reg, act_stamp_next;

    logic        out_valid_reg;
    event_t      event_reg, event_next;
    logic [31:0] idle_ms_reg;
    logic        idle_reg;

    logic                 s1_adv;
    logic                 next_down, prev_down;
    logic [CMP_W-1:0]     now_cmp;
    logic [TIME_BITS-1:0] now_t;
    logic [CMP_W-1:0]     chord_el, next_el, prev_el, idle_cmp;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;

    assign next_down = !s1_next_reg;
    assign prev_down = !s1_prev_reg;
    assign now_cmp   = CMP_W'(s1_now_reg);
    assign now_t     = now_cmp[TIME_BITS-1:0];

    assign chord_el = CMP_W'(TIME_BITS'(now_t - chord_stamp_reg));
    assign next_el  = CMP_W'(TIME_BITS'(now_t - next_stamp_reg));
    assign prev_el  = CMP_W'(TIME_BITS'(now_t - prev_stamp_reg));

    always_comb
    begin
        next_held_next   = next_held_reg;
        prev_held_next   = prev_held_reg;
        chord_held_next  = chord_held_reg;
        long_rep_next    = long_rep_reg;
        next_stamp_next  = next_stamp_reg;
        prev_stamp_next  = prev_stamp_reg;
        chord_stamp_next = chord_stamp_reg;
        act_stamp_next   = act_stamp_reg;
        event_next       = EV_NONE;

        if (s1_func_reg)
        begin
            act_stamp_next = now_t;
        end
        else if (next_down && prev_down)
        begin
            if (!chord_held_reg)
            begin
                chord_held_next  = 1'b1;
                chord_stamp_next = now_t;
                act_stamp_next   = now_t;
                long_rep_next    = 1'b0;
                event_next       = EV_BOTH;
            end
            else if (chord_el >= CMP_W'(long_press_reg) && !long_rep_reg)
            begin
                long_rep_next = 1'b1;
                event_next    = EV_BOTH_LONG;
            end
            next_held_next = 1'b1;
            prev_held_next = 1'b1;
        end
        else if (!next_down && !prev_down)
        begin
            if (chord_held_reg && long_rep_reg)
            begin
                event_next = EV_LONG_REL;
            end
            next_held_next  = 1'b0;
            prev_held_next  = 1'b0;
            chord_held_next = 1'b0;
            long_rep_next   = 1'b0;
        end
        else if (next_down)
        begin
            if (!next_held_reg && !chord_held_reg && next_el >= CMP_W'(debounce_reg))
            begin
                next_held_next  = 1'b1;
                next_stamp_next = now_t;
                act_stamp_next  = now_t;
                event_next      = EV_NEXT;
            end
            prev_held_next  = 1'b0;
            chord_held_next = 1'b0;
        end
        else
        begin
            if (!prev_held_reg && !chord_held_reg && prev_el >= CMP_W'(debounce_reg))
            begin
                prev_held_next  = 1'b1;
                prev_stamp_next = now_t;
                act_stamp_next  = now_t;
                event_next      = EV_PREV;
            end
            next_held_next  = 1'b0;
            chord_held_next = 1'b0;
        end
    end

    assign idle_cmp = CMP_W'(TIME_BITS'(now_t - act_stamp_next));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg    <= DEBOUNCE_W'(50);
            long_press_reg  <= LONG_PRESS_W'(5000);
            idle_limit_reg  <= IDLE_LIMIT_W'(60000);
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            next_held_reg   <= 1'b0;
            prev_held_reg   <= 1'b0;
            chord_held_reg  <= 1'b0;
            long_rep_reg    <= 1'b0;
            next_stamp_reg  <= '0;
            prev_stamp_reg  <= '0;
            chord_stamp_reg <= '0;
            act_stamp_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_DEBOUNCE:   debounce_reg   <= cfg_data[DEBOUNCE_W-1:0];
                    REG_LONG_PRESS: long_press_reg <= cfg_data[LONG_PRESS_W-1:0];
                    REG_IDLE_LIMIT: idle_limit_reg <= cfg_data[IDLE_LIMIT_W-1:0];
                    default:        ;
                endcase
            end

            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end

            if (s1_adv && s1_valid_reg)
            begin
                next_held_reg   <= next_held_next;
                prev_held_reg   <= prev_held_next;
                chord_held_reg  <= chord_held_next;
                long_rep_reg    <= long_rep_next;
                next_stamp_reg  <= next_stamp_next;
                prev_stamp_reg  <= prev_stamp_next;
                chord_stamp_reg <= chord_stamp_next;
                act_stamp_reg   <= act_stamp_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_func_reg <= func;
            s1_next_reg <= next_level;
            s1_prev_reg <= prev_level;
            s1_now_reg  <= now_ms;
        end
        if (s1_adv && s1_valid_reg)
        begin
            event_reg   <= event_next;
            idle_ms_reg <= idle_cmp[31:0];
            idle_reg    <= (idle_cmp >= CMP_W'(idle_limit_reg));
        end
    end

    assign out_valid = out_valid_reg;
    assign event_res = event_reg;
    assign idle_ms   = idle_ms_reg;
    assign idle      = idle_reg;

`ifndef NO_ASSERTIONS
    a_chord_implies_both_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        chord_held_reg |-> (next_held_reg && prev_held_reg)
    ) else $error("chord held without both buttons held");

    a_long_event_sets_flag: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_valid_reg && event_next == EV_BOTH_LONG)
            |=> (long_rep_reg && chord_held_reg && out_valid_reg)
    ) else $error("long press reported without long flag set");

    a_restart_zero_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_valid_reg && s1_func_reg)
            |=> (idle_ms_reg == 32'd0 && event_reg == EV_NONE)
    ) else $error("timer restart gave nonzero idle time or an event");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(idle_ms_reg))
    ) else $error("stalled result changed");
`endif

endmodule

### sim/chord_result_checker.sv
module chord_result_checker
    import tcq_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  logic                    func,
    input  logic                    next_level,
    input  logic                    prev_level,
    input  logic [STAMP_IN_W-1:0]   now_ms,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [2:0]              event_res,
    input  logic [31:0]             idle_ms,
    input  logic                    idle,
    input  logic                    drain_done,
    output int                      fail_count,
    output int                      result_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        event_t      ev;
        logic [31:0] idle_time;
        logic        idle_flag;
    } chord_result_t;

    chord_result_t expected_results[$];

    logic [DEBOUNCE_W-1:0]   debounce_cfg;
    logic [LONG_PRESS_W-1:0] hold_cfg;
    logic [IDLE_LIMIT_W-1:0] idle_limit_cfg;

    logic        next_latched;
    logic        prev_latched;
    logic        chord_active;
    logic        long_done;
    logic [31:0] next_press_t;
    logic [31:0] prev_press_t;
    logic [31:0] chord_start_t;
    logic [31:0] last_activity_t;

    initial
    begin
        fail_count = 0;
        result_count = 0;
    end

    task flag_mismatch(input string what);
        fail_count++;
        if (fail_count <= 40)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
    endtask

    task qualify_sample(input logic restart, input logic nl, input logic pl,
                        input logic [31:0] t, output chord_result_t r);
        logic        next_down;
        logic        prev_down;
        logic [31:0] since;
        next_down = !nl;
        prev_down = !pl;
        r.ev = EV_NONE;
        if (restart)
        begin
            last_activity_t = t;
        end
        else if (next_down && prev_down)
        begin
            since = t - chord_start_t;
            if (!chord_active)
            begin
                chord_active = 1'b1;
                chord_start_t = t;
                last_activity_t = t;
                long_done = 1'b0;
                r.ev = EV_BOTH;
            end
            else if (since >= {12'd0, hold_cfg} && !long_done)
            begin
                long_done = 1'b1;
                r.ev = EV_BOTH_LONG;
            end
            next_latched = 1'b1;
            prev_latched = 1'b1;
        end
        else if (!next_down && !prev_down)
        begin
            if (chord_active && long_done)
            begin
                r.ev = EV_LONG_REL;
            end
            next_latched = 1'b0;
            prev_latched = 1'b0;
            chord_active = 1'b0;
            long_done = 1'b0;
        end
        else if (next_down)
        begin
            since = t - next_press_t;
            if (!next_latched && !chord_active && since >= {16'd0, debounce_cfg})
            begin
                next_latched = 1'b1;
                next_press_t = t;
                last_activity_t = t;
                r.ev = EV_NEXT;
            end
            prev_latched = 1'b0;
            chord_active = 1'b0;
        end
        else
        begin
            since = t - prev_press_t;
            if (!prev_latched && !chord_active && since >= {16'd0, debounce_cfg})
            begin
                prev_latched = 1'b1;
                prev_press_t = t;
                last_activity_t = t;
                r.ev = EV_PREV;
            end
            next_latched = 1'b0;
            chord_active = 1'b0;
        end
        r.idle_time = t - last_activity_t;
        r.idle_flag = (r.idle_time >= idle_limit_cfg);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        chord_result_t want;
        if (!rst_n)
        begin
            debounce_cfg = 16'd50;
            hold_cfg = 20'd5000;
            idle_limit_cfg = 32'd60000;
            next_latched = 1'b0;
            prev_latched = 1'b0;
            chord_active = 1'b0;
            long_done = 1'b0;
            next_press_t = '0;
            prev_press_t = '0;
            chord_start_t = '0;
            last_activity_t = '0;
            result_count = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEBOUNCE:   debounce_cfg = cfg_data[DEBOUNCE_W-1:0];
                    REG_LONG_PRESS: hold_cfg = cfg_data[LONG_PRESS_W-1:0];
                    REG_IDLE_LIMIT: idle_limit_cfg = cfg_data[IDLE_LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                qualify_sample(func, next_level, prev_level, now_ms, want);
                expected_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                result_count++;
                if (expected_results.size() == 0)
                begin
                    flag_mismatch("result arrived with no request outstanding");
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (event_res !== want.ev)
                    begin
                        flag_mismatch($sformatf("event_res %0d, expected %0d",
                                                event_res, want.ev));
                    end
                    if (idle_ms !== want.idle_time)
                    begin
                        flag_mismatch($sformatf("idle_ms %0d, expected %0d",
                                                idle_ms, want.idle_time));
                    end
                    if (idle !== want.idle_flag)
                    begin
                        flag_mismatch($sformatf("idle %0b, expected %0b",
                                                idle, want.idle_flag));
                    end
                end
            end
        end
    end

    always @(posedge drain_done)
    begin
        if (expected_results.size() != 0)
        begin
            flag_mismatch($sformatf("%0d results never arrived",
                                    expected_results.size()));
        end
    end

endmodule

### sim/testbench.sv
module testbench
    import tcq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_POLL    = 1'b0;
    localparam logic OP_RESTART = 1'b1;
    localparam logic PRESSED    = 1'b0;
    localparam logic RELEASED   = 1'b1;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = '1;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    func = 1'b0;
    logic                    next_level = 1'b1;
    logic                    prev_level = 1'b1;
    logic [STAMP_IN_W-1:0]   now_ms = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [2:0]              event_res;
    logic [31:0]             idle_ms;
    logic                    idle;
    logic                    drain_done = 1'b0;
    logic                    quiet = 1'b0;

    int fail_count;
    int result_count;
    int sent_count = 0;

    logic [31:0] clock_ms = '0;
    logic [15:0] cur_debounce = 16'd50;
    logic [19:0] cur_hold = 20'd5000;
    logic [31:0] cur_limit = 32'd60000;

    two_button_chord_qualifier u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .next_level (next_level),
        .prev_level (prev_level),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .idle_ms    (idle_ms),
        .idle       (idle)
    );

    chord_result_checker u_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .next_level   (next_level),
        .prev_level   (prev_level),
        .now_ms       (now_ms),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .event_res    (event_res),
        .idle_ms      (idle_ms),
        .idle         (idle),
        .drain_done   (drain_done),
        .fail_count   (fail_count),
        .result_count (result_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("two_button_chord_qualifier verification failed");
        $finish;
    end

    initial
    begin : stall_gen
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (burst > 0)
            begin
                burst--;
            end
            else if (!quiet && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 12);
            end
            out_stall <= (burst > 0);
        end
    end

    task automatic send(input logic f, input logic nl, input logic pl, input logic [31:0] t);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        next_level <= nl;
        prev_level <= pl;
        now_ms <= t;
        do @(posedge clk); while (in_stall);
        sent_count++;
    endtask

    task automatic poll(input logic nl, input logic pl, input logic [31:0] step);
        clock_ms = clock_ms + step;
        send(OP_POLL, nl, pl, clock_ms);
    endtask

    task automatic load_config(input logic [15:0] d, input logic [19:0] hold,
                               input logic [31:0] lim);
        in_valid <= 1'b0;
        wait (result_count == sent_count);
        repeat (4) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_DEBOUNCE;
        cfg_data <= {16'($urandom), d};
        @(posedge clk);
        cfg_index <= REG_LONG_PRESS;
        cfg_data <= {12'($urandom), hold};
        @(posedge clk);
        cfg_index <= REG_IDLE_LIMIT;
        cfg_data <= lim;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data <= $urandom;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        cur_debounce = d;
        cur_hold = hold;
        cur_limit = lim;
    endtask

    task automatic run_phase(input int count);
        int          first;
        int          kind;
        logic        which;
        logic [31:0] hold_span;
        logic [31:0] tap_span;
        logic [31:0] idle_span;
        first = sent_count;
        hold_span = cur_hold + cur_hold / 2 + 32'd2;
        tap_span = 2 * cur_debounce + 32'd2;
        idle_span = (cur_limit > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : 2 * cur_limit + 32'd2;
        while (sent_count - first < count)
        begin
            kind = $urandom_range(0, 99);
            which = 1'($urandom_range(0, 1));
            if (kind < 40)
            begin
                poll(PRESSED, PRESSED, $urandom_range(0, tap_span));
                repeat ($urandom_range(0, 4))
                begin
                    poll(PRESSED, PRESSED, $urandom_range(0, hold_span));
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    poll(which ? PRESSED : RELEASED, which ? RELEASED : PRESSED,
                         $urandom_range(0, tap_span));
                    if ($urandom_range(0, 1) == 0)
                    begin
                        poll(which ? RELEASED : PRESSED, which ? PRESSED : RELEASED,
                             $urandom_range(0, tap_span));
                    end
                end
                poll(RELEASED, RELEASED, ($urandom_range(0, 7) == 0)
                     ? $urandom_range(0, idle_span) : $urandom_range(0, 20));
            end
            else if (kind < 75)
            begin
                poll(which ? PRESSED : RELEASED, which ? RELEASED : PRESSED,
                     $urandom_range(0, tap_span));
                repeat ($urandom_range(0, 2))
                begin
                    poll(which ? PRESSED : RELEASED, which ? RELEASED : PRESSED,
                         $urandom_range(0, 30));
                end
                poll(RELEASED, RELEASED, ($urandom_range(0, 7) == 0)
                     ? $urandom_range(0, idle_span) : $urandom_range(0, 20));
            end
            else if (kind < 85)
            begin
                clock_ms = clock_ms + $urandom_range(0, tap_span);
                send(OP_RESTART, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     clock_ms);
            end
            else
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    clock_ms = $urandom;
                end
                else
                begin
                    clock_ms = clock_ms + $urandom_range(0, 100);
                end
                send(($urandom_range(0, 3) == 0) ? OP_RESTART : OP_POLL,
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), clock_ms);
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(OP_POLL, PRESSED, RELEASED, 32'd10);
        send(OP_POLL, PRESSED, RELEASED, 32'd60);
        send(OP_POLL, PRESSED, RELEASED, 32'd70);
        send(OP_POLL, RELEASED, RELEASED, 32'd80);
        send(OP_POLL, PRESSED, RELEASED, 32'd100);
        send(OP_POLL, RELEASED, RELEASED, 32'd120);
        send(OP_POLL, RELEASED, PRESSED, 32'd130);
        send(OP_POLL, PRESSED, PRESSED, 32'd140);
        send(OP_POLL, PRESSED, PRESSED, 32'd3000);
        send(OP_POLL, PRESSED, PRESSED, 32'd5140);
        send(OP_POLL, PRESSED, PRESSED, 32'd6000);
        send(OP_POLL, RELEASED, RELEASED, 32'd6100);
        send(OP_POLL, PRESSED, PRESSED, 32'd6200);
        send(OP_POLL, PRESSED, PRESSED, 32'd11300);
        send(OP_POLL, PRESSED, RELEASED, 32'd11400);
        send(OP_POLL, RELEASED, RELEASED, 32'd11500);
        send(OP_RESTART, PRESSED, PRESSED, 32'd20000);
        send(OP_POLL, RELEASED, RELEASED, 32'd90000);
        send(OP_RESTART, RELEASED, RELEASED, 32'hFFFF_FFF0);
        send(OP_POLL, PRESSED, RELEASED, 32'h0000_0010);
        send(OP_POLL, RELEASED, PRESSED, 32'hFFFF_FFFF);
        send(OP_POLL, PRESSED, PRESSED, 32'h0000_0000);
        send(OP_RESTART, RELEASED, PRESSED, 32'h0000_0000);
        send(OP_POLL, RELEASED, RELEASED, 32'd59999);
        send(OP_POLL, RELEASED, RELEASED, 32'd60000);
        clock_ms = 32'd60000;

        load_config(16'd0, 20'd0, 32'd0);
        run_phase(115);
        load_config(16'hFFFF, 20'hF_FFFF, 32'hFFFF_FFFF);
        run_phase(115);
        load_config(16'd20, 20'd300, 32'd2000);
        run_phase(115);
        load_config(16'($urandom_range(0, 300)), 20'($urandom_range(0, 4000)),
                    $urandom_range(0, 50000));
        run_phase(115);
        load_config(16'd50, 20'd5000, 32'd60000);
        run_phase(115);
        load_config(16'($urandom_range(0, 200)), 20'($urandom_range(0, 3000)),
                    $urandom_range(0, 30000));
        quiet = 1'b1;
        run_phase(115);

        in_valid <= 1'b0;
        wait (result_count == sent_count);
        repeat (10) @(posedge clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("two_button_chord_qualifier verification clean");
        end
        else
        begin
            $display("two_button_chord_qualifier verification failed");
        end
        $finish;
    end

endmodule

### sim.f
hdl/tcq_pkg.sv
hdl/two_button_chord_qualifier.sv
sim/chord_result_checker.sv
sim/testbench.sv
